// File: rtl/ics_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ics_pkg: shared types and constants for the Ising chain spin update unit
// Word formats, register indexes, controller/datapath links, exp coefficients.
// ----------------------------------------------------------------------------
package ics_pkg;

  localparam int MAX_SPINS_DEF = 256;

  localparam logic [16:0] LOG2E_Q16 = 17'd94548;
  localparam logic [31:0] ONE_Q30   = 32'd1073741824;
  localparam logic [16:0] ONE_Q16   = 17'h10000;
  localparam logic [31:0] POLY_TOP  = 32'd165394;

  typedef enum logic [2:0] {
    CFG_USE_METRO  = 3'd0,
    CFG_SPIN_COUNT = 3'd1,
    CFG_COUPLING   = 3'd2,
    CFG_FIELD      = 3'd3,
    CFG_BETA       = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic        mode;
    logic [7:0]  site;
    logic        spin_value;
    logic [15:0] random_draw;
  } in_word_t;

  typedef struct packed {
    logic [7:0]         site_out;
    logic               new_spin;
    logic               flipped;
    logic signed [19:0] energy_change;
  } out_word_t;

  typedef struct packed {
    logic clr_step;
    logic load_item;
    logic rd_center;
    logic rd_left;
    logic rd_right;
    logic cap_center;
    logic cap_left;
    logic cap_right;
    logic calc;
    logic mul_a;
    logic mul_y;
    logic exp_zero;
    logic poly_init;
    logic poly_step;
    logic exp_shift;
    logic div_init;
    logic div_step;
    logic decide;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic in_range;
    logic is_update;
    logic use_metro;
    logic de_pos;
    logic k_big;
    logic poly_last;
    logic div_last;
    logic out_free;
  } dp_sts_t;

  // Horner order: c4, c3, c2, c1, c0, then one
  function automatic logic [31:0] poly_coef(input logic [2:0] idx);
    logic [31:0] c;
    case (idx)
      3'd0: c = 32'd1431680;
      3'd1: c = 32'd10327388;
      3'd2: c = 32'd59597083;
      3'd3: c = 32'd257941248;
      3'd4: c = 32'd744261118;
      default: c = ONE_Q30;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

// File: rtl/ics_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ics_ctrl: sequencer for the spin update unit
// Walks clear pass, neighbor reads, exp evaluation, divide and write-back.
// ----------------------------------------------------------------------------
module ics_ctrl
  import ics_pkg::*;
(
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          in_valid_i,
  output logic         in_ready_o,
  input  wire dp_sts_t sts_i,
  output dp_cmd_t      cmd_o
);

  typedef enum logic [14:0] {
    S_CLEAR    = 15'b000000000000001,
    S_IDLE     = 15'b000000000000010,
    S_RD_C     = 15'b000000000000100,
    S_RD_L     = 15'b000000000001000,
    S_RD_R     = 15'b000000000010000,
    S_RD_W     = 15'b000000000100000,
    S_CALC     = 15'b000000001000000,
    S_MUL_A    = 15'b000000010000000,
    S_MUL_Y    = 15'b000000100000000,
    S_EXP_CHK  = 15'b000001000000000,
    S_POLY     = 15'b000010000000000,
    S_SHIFT    = 15'b000100000000000,
    S_DIV_INIT = 15'b001000000000000,
    S_DIV      = 15'b010000000000000,
    S_DECIDE   = 15'b100000000000000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d = S_RD_C;
        end
      end
      S_RD_C: begin
        cmd_o.rd_center = 1'b1;
        state_d = S_RD_L;
      end
      S_RD_L: begin
        cmd_o.rd_left    = 1'b1;
        cmd_o.cap_center = 1'b1;
        state_d = S_RD_R;
      end
      S_RD_R: begin
        cmd_o.rd_right = 1'b1;
        cmd_o.cap_left = 1'b1;
        state_d = S_RD_W;
      end
      S_RD_W: begin
        cmd_o.cap_right = 1'b1;
        state_d = S_CALC;
      end
      S_CALC: begin
        cmd_o.calc = 1'b1;
        if (!sts_i.in_range || !sts_i.is_update) begin
          state_d = S_DECIDE;
        end else if (sts_i.use_metro && !sts_i.de_pos) begin
          state_d = S_DECIDE;
        end else begin
          state_d = S_MUL_A;
        end
      end
      S_MUL_A: begin
        cmd_o.mul_a = 1'b1;
        state_d = S_MUL_Y;
      end
      S_MUL_Y: begin
        cmd_o.mul_y = 1'b1;
        state_d = S_EXP_CHK;
      end
      S_EXP_CHK: begin
        if (sts_i.k_big) begin
          cmd_o.exp_zero = 1'b1;
          state_d = sts_i.use_metro ? S_DECIDE : S_DIV_INIT;
        end else begin
          cmd_o.poly_init = 1'b1;
          state_d = S_POLY;
        end
      end
      S_POLY: begin
        cmd_o.poly_step = 1'b1;
        if (sts_i.poly_last) state_d = S_SHIFT;
      end
      S_SHIFT: begin
        cmd_o.exp_shift = 1'b1;
        state_d = sts_i.use_metro ? S_DECIDE : S_DIV_INIT;
      end
      S_DIV_INIT: begin
        cmd_o.div_init = 1'b1;
        state_d = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) state_d = S_DECIDE;
      end
      S_DECIDE: begin
        if (sts_i.out_free) begin
          cmd_o.decide = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_CLEAR;
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/ics_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ics_datapath: spin store, config registers and arithmetic
// Local field, exp(-x) by Horner, restoring divide, output register.
// ----------------------------------------------------------------------------
module ics_datapath
  import ics_pkg::*;
#(
  parameter int MAX_SPINS = MAX_SPINS_DEF
) (
  input  wire           clk_i,
  input  wire           rst_ni,
  input  wire dp_cmd_t  cmd_i,
  output dp_sts_t       sts_o,
  input  wire in_word_t in_word_i,
  input  wire           cfg_we_i,
  input  wire  [2:0]    cfg_idx_i,
  input  wire [15:0]    cfg_data_i,
  output logic          out_valid_o,
  input  wire           out_ready_i,
  output out_word_t     out_word_o
);

  localparam int AW = (MAX_SPINS > 1) ? $clog2(MAX_SPINS) : 1;
  localparam int NW = $clog2(MAX_SPINS + 1);
  localparam int CW = (NW > 9) ? NW : 9;

  logic        use_metro_q;
  logic [8:0]  spin_count_q;
  logic [15:0] coupling_q, field_q, beta_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      use_metro_q  <= 1'b1;
      spin_count_q <= 9'd256;
      coupling_q   <= 16'd4096;
      field_q      <= 16'd0;
      beta_q       <= 16'd4096;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_USE_METRO:  use_metro_q  <= cfg_data_i[0];
        CFG_SPIN_COUNT: spin_count_q <= cfg_data_i[8:0];
        CFG_COUPLING:   coupling_q   <= cfg_data_i;
        CFG_FIELD:      field_q      <= cfg_data_i;
        CFG_BETA:       beta_q       <= cfg_data_i;
        default: ;
      endcase
    end
  end

  in_word_t item_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) item_q <= in_word_i;
  end

  // ring geometry
  logic [CW-1:0] sc_w, n_w, site_w, left_w, right_w;
  logic          in_range, in_store;
  always_comb begin
    sc_w = CW'(spin_count_q);
    if (sc_w < CW'(3)) begin
      n_w = CW'(3);
    end else if (sc_w > CW'(MAX_SPINS)) begin
      n_w = CW'(MAX_SPINS);
    end else begin
      n_w = sc_w;
    end
    site_w   = CW'(item_q.site);
    in_range = site_w < n_w;
    in_store = site_w < CW'(MAX_SPINS);
    left_w   = (site_w == '0) ? n_w - CW'(1) : site_w - CW'(1);
    right_w  = (site_w + CW'(1) == n_w) ? '0 : site_w + CW'(1);
  end

  // spin store
  logic          mem_q [MAX_SPINS];
  logic          rd_data_q;
  logic [AW-1:0] clr_cnt_q, raddr, waddr;
  logic          mem_we, mem_wdata, new_bit;

  always_comb begin
    raddr = AW'(site_w);
    if (cmd_i.rd_left)  raddr = AW'(left_w);
    if (cmd_i.rd_right) raddr = AW'(right_w);
    mem_we    = cmd_i.clr_step | (cmd_i.decide & in_range);
    waddr     = cmd_i.clr_step ? clr_cnt_q : AW'(site_w);
    mem_wdata = cmd_i.clr_step | new_bit;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[waddr] <= mem_wdata;
    rd_data_q <= mem_q[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clr_step) begin
      clr_cnt_q <= clr_cnt_q + AW'(1);
    end
  end

  logic old_q, left_q, right_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_center) old_q   <= rd_data_q;
    if (cmd_i.cap_left)   left_q  <= rd_data_q;
    if (cmd_i.cap_right)  right_q <= rd_data_q;
  end

  // local field and energy change
  logic signed [17:0] j2, jn, local_d, local_q;
  logic signed [18:0] de_d, de_q;
  always_comb begin
    j2 = {coupling_q[15], coupling_q, 1'b0};
    if (left_q && right_q) begin
      jn = j2;
    end else if (!left_q && !right_q) begin
      jn = -j2;
    end else begin
      jn = '0;
    end
    local_d = jn + {{2{field_q[15]}}, field_q};
    de_d    = old_q ? {local_d, 1'b0} : -{local_d, 1'b0};
  end

  // exp(-a) and divide
  logic [16:0] abs_l;
  logic [17:0] m_w;
  logic [33:0] a_q;
  logic [50:0] y_prod;
  logic [26:0] y_q;
  logic [10:0] k_w;
  logic [15:0] f_w;
  logic [47:0] pm;
  logic [31:0] acc_q;
  logic [2:0]  poly_cnt_q;
  logic [4:0]  sh_w;
  logic [16:0] pe_q, quo_q;
  logic [17:0] d_q;
  logic [18:0] rem_q, rem_t;
  logic [4:0]  div_cnt_q;

  always_comb begin
    abs_l  = local_q[17] ? 17'(-local_q) : local_q[16:0];
    m_w    = use_metro_q ? de_q[17:0] : {abs_l, 1'b0};
    y_prod = 51'(a_q) * 51'(LOG2E_Q16);
    k_w    = y_q[26:16];
    f_w    = y_q[15:0];
    pm     = 48'(f_w) * 48'(acc_q);
    sh_w   = 5'd14 + k_w[4:0];
    rem_t  = {rem_q[17:0], 1'b0};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc) begin
      local_q <= local_d;
      de_q    <= de_d;
    end
    if (cmd_i.mul_a)     a_q   <= 34'(beta_q) * 34'(m_w);
    if (cmd_i.mul_y)     y_q   <= y_prod[50:24];
    if (cmd_i.poly_init) acc_q <= POLY_TOP;
    if (cmd_i.poly_step) acc_q <= poly_coef(poly_cnt_q) - pm[47:16];
    if (cmd_i.exp_zero)  pe_q  <= '0;
    if (cmd_i.exp_shift) pe_q  <= 17'(acc_q >> sh_w);
    if (cmd_i.div_init) begin
      d_q   <= 18'(ONE_Q16) + 18'(pe_q);
      rem_q <= 19'h08000;
      quo_q <= '0;
    end
    if (cmd_i.div_step) begin
      if (rem_t >= {1'b0, d_q}) begin
        rem_q <= rem_t - {1'b0, d_q};
        quo_q <= {quo_q[15:0], 1'b1};
      end else begin
        rem_q <= rem_t;
        quo_q <= {quo_q[15:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poly_cnt_q <= '0;
      div_cnt_q  <= '0;
    end else begin
      if (cmd_i.poly_init) poly_cnt_q <= '0;
      else if (cmd_i.poly_step) poly_cnt_q <= poly_cnt_q + 3'd1;
      if (cmd_i.div_init) div_cnt_q <= '0;
      else if (cmd_i.div_step) div_cnt_q <= div_cnt_q + 5'd1;
    end
  end

  // decision
  logic [16:0] p_m, p_g, draw17;
  logic        flip;
  always_comb begin
    p_m    = (de_q > 0) ? pe_q : ONE_Q16;
    p_g    = local_q[17] ? ONE_Q16 - quo_q : quo_q;
    draw17 = {1'b0, item_q.random_draw};
    if (!in_range) begin
      new_bit = in_store & old_q;
    end else if (!item_q.mode) begin
      new_bit = item_q.spin_value;
    end else if (use_metro_q) begin
      new_bit = (draw17 <= p_m) ? ~old_q : old_q;
    end else begin
      new_bit = draw17 <= p_g;
    end
    flip = in_range && (new_bit != old_q);
  end

  out_word_t out_q;
  logic      out_valid_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.decide) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.decide) begin
      out_q.site_out      <= item_q.site;
      out_q.new_spin      <= new_bit;
      out_q.flipped       <= flip;
      out_q.energy_change <= flip ? {de_q[18], de_q} : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  always_comb begin
    sts_o           = '0;
    sts_o.clr_last  = clr_cnt_q == AW'(MAX_SPINS - 1);
    sts_o.in_range  = in_range;
    sts_o.is_update = item_q.mode;
    sts_o.use_metro = use_metro_q;
    sts_o.de_pos    = de_d > 0;
    sts_o.k_big     = k_w >= 11'd17;
    sts_o.poly_last = poly_cnt_q == 3'd5;
    sts_o.div_last  = div_cnt_q == 5'd16;
    sts_o.out_free  = !out_valid_q || out_ready_i;
  end

`ifndef SYNTH
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.decide |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten");
  a_clr_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.clr_step && (cmd_i.decide || cmd_i.load_item)))
    else $error("item handled during clear pass");
  a_flip_energy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.flipped) |-> (out_q.energy_change == '0))
    else $error("energy change without flip");
  a_div_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |-> (div_cnt_q <= 5'd16))
    else $error("divider overran");
`endif

endmodule
`default_nettype wire

// File: rtl/ising_chain_spin_update_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ising_chain_spin_update_unit: Metropolis / heat-bath step on a spin ring
// Usage:
//   in channel (in_valid_i/in_ready_o, in_word_i) takes one word per item:
//   a spin load or an update attempt at a site. out channel
//   (out_valid_o/out_ready_i, out_word_o) returns one word per item.
//   Config writes (cfg_we_i, cfg_idx_i, cfg_data_i) take effect at once;
//   write only while idle.
// Sequence, accept to result valid, set by the sequencer:
//   load, off-ring site, or downhill Metropolis move: reads, calc, decide;
//   Metropolis uphill: two multiplies, then early zero or Horner loop;
//   Gibbs: as uphill, then a 17-step restoring divide (6-step Horner loop).
//   One item in flight; the next item can be taken in the same cycle that
//   its result becomes valid.
// Reset: config returns to defaults and a clearing pass writes all MAX_SPINS
//   entries, setting every spin to +1; no word is taken until it ends.
// Receiver stall: the result waits in the output register; the next item
//   is accepted and processed up to its write-back, which waits for room.
// ----------------------------------------------------------------------------
module ising_chain_spin_update_unit
  import ics_pkg::*;
#(
  parameter int MAX_SPINS = MAX_SPINS_DEF
) (
  input  wire           clk_i,
  input  wire           rst_ni,
  input  wire           in_valid_i,
  output logic          in_ready_o,
  input  wire in_word_t in_word_i,
  output logic          out_valid_o,
  input  wire           out_ready_i,
  output out_word_t     out_word_o,
  input  wire           cfg_we_i,
  input  wire  [2:0]    cfg_idx_i,
  input  wire [15:0]    cfg_data_i
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  ics_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ics_datapath #(
    .MAX_SPINS (MAX_SPINS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_word_i   (in_word_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

endmodule
`default_nettype wire
